[hdl/assert_macros.svh]
// Assertion macros for the RTL files.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IDC_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication, disabled in reset.
`define IDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/idc_pkg.sv]
// Package for the drag coefficient block: widths, register codes, item types,
// and the sqrt / divide step functions. No dependencies.
package idc_pkg;

    localparam int NUM_CELLS = 4096;
    localparam int CELL_W    = 12;
    localparam int COEF_W    = 48;
    localparam int FRAC_W    = 17;
    localparam int SPEED_W   = 16;
    localparam int VEL_W     = 32;
    localparam int VOL_W     = 32;

    localparam logic [FRAC_W-1:0] FRAC_NEAR_ONE = 17'd65530;
    localparam logic [FRAC_W-1:0] FRAC_ONE      = 17'd65536;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRAC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE   = 3'd4;

    // sqrt: 70-bit radicand, two bits per step
    localparam int SQ_IN_W    = 70;
    localparam int SQ_REM_W   = 38;
    localparam int SQ_ROOT_W  = 35;
    localparam int SQRT_ITERS = SQ_IN_W / 2;

    // divide: 67-bit divisor, 48 quotient bits
    localparam int D_W        = SQ_ROOT_W + VOL_W;
    localparam int DIV_REM_W  = D_W + 1;
    localparam int DIV_ITERS  = COEF_W;

    localparam int LAT_CALC = 3 + SQRT_ITERS + 2 + DIV_ITERS + 1;
    localparam int CNT_W    = $clog2(LAT_CALC + 4);

    localparam int IN_BITS     = CELL_W + 9 * VEL_W + FRAC_W + VOL_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = CELL_W + 2 * COEF_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // last listed field (cell_index) in the low bits
    typedef struct packed {
        logic        [VOL_W-1:0]  cell_volume;
        logic signed [VEL_W-1:0]  force_z;
        logic signed [VEL_W-1:0]  force_y;
        logic signed [VEL_W-1:0]  force_x;
        logic        [FRAC_W-1:0] void_fraction;
        logic signed [VEL_W-1:0]  solid_vel_z;
        logic signed [VEL_W-1:0]  solid_vel_y;
        logic signed [VEL_W-1:0]  solid_vel_x;
        logic signed [VEL_W-1:0]  fluid_vel_z;
        logic signed [VEL_W-1:0]  fluid_vel_y;
        logic signed [VEL_W-1:0]  fluid_vel_x;
        logic        [CELL_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] cidx;
        logic [COEF_W-1:0] next;
        logic              limited;
    } t_calc_res;

    typedef struct packed {
        logic [SQ_IN_W-1:0]   v;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [D_W-1:0]       d;
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_ITERS-1:0] v;
        logic [COEF_W-1:0]    q;
        logic                 ok;
        logic                 sat;
    } t_div_st;

    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        t_sqrt_st r;
        logic [SQ_REM_W-1:0] t;
        logic [SQ_REM_W-1:0] trial;
        t     = {s.rem[SQ_REM_W-3:0], s.v[SQ_IN_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.v   = {s.v[SQ_IN_W-3:0], 2'b00};
        if (t >= trial) begin
            r.rem  = t - trial;
            r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t;
            r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_div_st div_step(input t_div_st s);
        t_div_st r;
        logic [DIV_REM_W-1:0] t;
        logic [DIV_REM_W-1:0] dd;
        t  = {s.rem[DIV_REM_W-2:0], s.v[DIV_ITERS-1]};
        dd = {1'b0, s.d};
        r  = s;
        r.v = {s.v[DIV_ITERS-2:0], 1'b0};
        if (t >= dd) begin
            r.rem = t - dd;
            r.q   = {s.q[COEF_W-2:0], 1'b1};
        end else begin
            r.rem = t;
            r.q   = {s.q[COEF_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [VEL_W:0] abs33(input logic signed [VEL_W:0] v);
        return v[VEL_W] ? -v : v;
    endfunction

endpackage

[hdl/idc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[hdl/idc_calc.sv]
// Coefficient pipeline: |U-Us|, |F|, bitwise sqrt, multiply, bitwise divide, clamp.
// Depends on idc_pkg.
module idc_calc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  idc_pkg::t_in_item             i_item,
    input  logic [idc_pkg::COEF_W-1:0]    i_coeff_limit,
    input  logic [idc_pkg::FRAC_W-1:0]    i_max_void,
    input  logic [idc_pkg::SPEED_W-1:0]   i_small_speed,
    output idc_pkg::t_calc_res            o_res
);
    import idc_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] cidx;
        logic              vf_ok;
        logic [VOL_W-1:0]  vol;
    } t_side;

    logic [LAT_CALC-1:0] r_vld;
    t_side               r_side [LAT_CALC];

    logic [VEL_W:0]      r1_d [3];
    logic [VEL_W-1:0]    r1_f [3];
    logic [2*VEL_W+1:0]  r2_d [3];
    logic [2*VEL_W-1:0]  r2_f [3];
    t_sqrt_st            r_squ [SQRT_ITERS+1];
    t_sqrt_st            r_sqf [SQRT_ITERS+1];
    logic [D_W-1:0]      r_m_d;
    logic [D_W-1:0]      r_m_n;
    logic                r_m_ok;
    t_div_st             r_dv [DIV_ITERS+1];
    logic [COEF_W-1:0]   r_f_next;
    logic                r_f_lim;

    logic [VEL_W:0] in_d [3];
    logic [VEL_W:0] in_f [3];
    t_side          side_in;
    logic           over;

    always_comb begin
        in_d[0] = abs33({i_item.fluid_vel_x[VEL_W-1], i_item.fluid_vel_x}
                      - {i_item.solid_vel_x[VEL_W-1], i_item.solid_vel_x});
        in_d[1] = abs33({i_item.fluid_vel_y[VEL_W-1], i_item.fluid_vel_y}
                      - {i_item.solid_vel_y[VEL_W-1], i_item.solid_vel_y});
        in_d[2] = abs33({i_item.fluid_vel_z[VEL_W-1], i_item.fluid_vel_z}
                      - {i_item.solid_vel_z[VEL_W-1], i_item.solid_vel_z});
        in_f[0] = abs33({i_item.force_x[VEL_W-1], i_item.force_x});
        in_f[1] = abs33({i_item.force_y[VEL_W-1], i_item.force_y});
        in_f[2] = abs33({i_item.force_z[VEL_W-1], i_item.force_z});
        side_in.cidx  = i_item.cell_index;
        side_in.vf_ok = i_item.void_fraction < i_max_void;
        side_in.vol   = i_item.cell_volume;
    end

    // valid and sideband shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT_CALC-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= side_in;
            for (int k = 1; k < LAT_CALC; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // abs, square, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= in_d[k];
                r1_f[k] <= in_f[k][VEL_W-1:0];
                r2_d[k] <= r1_d[k] * r1_d[k];
                r2_f[k] <= r1_f[k] * r1_f[k];
            end
            r_squ[0].v    <= SQ_IN_W'(r2_d[0]) + SQ_IN_W'(r2_d[1]) + SQ_IN_W'(r2_d[2]);
            r_squ[0].rem  <= '0;
            r_squ[0].root <= '0;
            r_sqf[0].v    <= SQ_IN_W'(r2_f[0]) + SQ_IN_W'(r2_f[1]) + SQ_IN_W'(r2_f[2]);
            r_sqf[0].rem  <= '0;
            r_sqf[0].root <= '0;
        end
    end

    // two radicand bits per stage
    for (genvar g = 0; g < SQRT_ITERS; g++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_squ[g+1] <= sqrt_step(r_squ[g]);
                r_sqf[g+1] <= sqrt_step(r_sqf[g]);
            end
        end
    end

    // divisor Ur*V, numerator Fm<<32, exchange condition
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_d  <= r_squ[SQRT_ITERS].root * r_side[SQRT_ITERS+2].vol;
            r_m_n  <= {r_sqf[SQRT_ITERS].root, 32'b0};
            r_m_ok <= (r_squ[SQRT_ITERS].root > SQ_ROOT_W'(i_small_speed))
                   && r_side[SQRT_ITERS+2].vf_ok;
        end
    end

    // quotient >= 2^48 is settled up front; a zero divisor lands there too
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0].d   <= r_m_d;
            r_dv[0].sat <= D_W'(r_m_n[D_W-1:COEF_W]) >= r_m_d;
            r_dv[0].rem <= DIV_REM_W'(r_m_n[D_W-1:COEF_W]);
            r_dv[0].v   <= r_m_n[COEF_W-1:0];
            r_dv[0].q   <= '0;
            r_dv[0].ok  <= r_m_ok;
        end
    end

    for (genvar g = 0; g < DIV_ITERS; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g+1] <= div_step(r_dv[g]);
            end
        end
    end

    assign over = r_dv[DIV_ITERS].sat || (r_dv[DIV_ITERS].q > i_coeff_limit);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_next <= !r_dv[DIV_ITERS].ok ? '0
                      : (over ? i_coeff_limit : r_dv[DIV_ITERS].q);
            r_f_lim  <= r_dv[DIV_ITERS].ok && over;
        end
    end

    assign o_res.valid   = r_vld[LAT_CALC-1];
    assign o_res.cidx    = r_side[LAT_CALC-1].cidx;
    assign o_res.next    = r_f_next;
    assign o_res.limited = r_f_lim;
endmodule

[hdl/implicit_drag_coefficient_cells.sv]
// Input accept to o_m_tvalid: calc pipeline, store access, output. The per-cell store is
// read then written back once per item; one item per cycle while the output skid is empty.
// Reset: synchronous active low; registers go to reset values and a clearing pass
// zeroes the 4096-entry store, one entry a cycle, during which no item is accepted.
// Depends on idc_pkg, idc_calc, idc_ram and assert_macros.svh.
`include "assert_macros.svh"
module implicit_drag_coefficient_cells (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream; tdata from bit 0: cell_index, fluid_vel_x/y/z, solid_vel_x/y/z,
    // void_fraction, force_x/y/z, cell_volume, zero fill
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [idc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master stream; tdata from bit 0: out_cell, source_coeff, next_coeff, zero fill
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [idc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // tuser: was_limited
    output logic                              o_m_tuser,
    // register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [idc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [idc_pkg::COEF_W-1:0]        i_cfg_data
);
    import idc_pkg::*;

    localparam int AW = $clog2(NUM_CELLS);

    // configuration
    logic [COEF_W-1:0]  r_coeff_limit;
    logic [FRAC_W-1:0]  r_max_void;
    logic [SPEED_W-1:0] r_small_speed;
    logic [FRAC_W-1:0]  r_step_frac;
    logic               r_pass_mode;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // items in flight, gates register writes
    logic [CNT_W-1:0] r_inflight;

    // writeback stage and the write it forwards from
    logic              r_b_valid;
    logic [CELL_W-1:0] r_b_cell;
    logic [COEF_W-1:0] r_b_next;
    logic              r_b_lim;
    logic              r_w_valid;
    logic [CELL_W-1:0] r_w_cell;
    logic [COEF_W-1:0] r_w_prev;
    logic [COEF_W-1:0] r_w_next;

    // output register and skid
    logic                r_o_valid;
    logic [OUT_BITS-1:0] r_o_data;
    logic                r_o_user;
    logic                r_s_valid;
    logic [OUT_BITS-1:0] r_s_data;
    logic                r_s_user;

    logic                  en;
    logic                  s_acc;
    t_calc_res             calc_res;
    logic [2*COEF_W-1:0]   rd_data;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [2*COEF_W-1:0]   ram_wdata;
    logic                  fwd;
    logic [COEF_W-1:0]     cur_prev;
    logic [COEF_W-1:0]     cur_next;
    logic                  is_step;
    logic [COEF_W-1:0]     wr_prev;
    logic [COEF_W-1:0]     wr_next;
    logic signed [COEF_W:0]       blend_diff;
    logic signed [COEF_W+FRAC_W+1:0] blend_prod;
    logic signed [COEF_W+FRAC_W+1:0] blend_sum;
    logic [COEF_W-1:0]     src;
    logic                  push;
    logic [OUT_BITS-1:0]   push_data;
    logic                  push_user;
    logic                  pop;

    // the whole pipeline stalls only when the skid holds a result
    assign en          = !r_s_valid;
    assign o_s_tready  = en && !r_clr_busy;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = (r_inflight == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_limit <= {COEF_W{1'b1}};
            r_max_void    <= FRAC_ONE;
            r_small_speed <= SPEED_W'(1);
            r_step_frac   <= FRAC_ONE;
            r_pass_mode   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COEFF_LIMIT: r_coeff_limit <= i_cfg_data;
                CFG_MAX_VOID:    r_max_void    <= i_cfg_data[FRAC_W-1:0];
                CFG_SMALL_SPEED: r_small_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_STEP_FRAC:   r_step_frac   <= i_cfg_data[FRAC_W-1:0];
                CFG_PASS_MODE:   r_pass_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(NUM_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(s_acc) - CNT_W'(en && r_b_valid);
        end
    end

    idc_calc u_calc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (s_acc),
        .i_item        (t_in_item'(i_s_tdata[IN_BITS-1:0])),
        .i_coeff_limit (r_coeff_limit),
        .i_max_void    (r_max_void),
        .i_small_speed (r_small_speed),
        .o_res         (calc_res)
    );

    // store entry: {next, prev}; read as the result leaves the calc pipeline
    idc_ram #(
        .WIDTH (2 * COEF_W),
        .DEPTH (NUM_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (calc_res.cidx[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= calc_res.valid;
            r_w_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cell <= calc_res.cidx;
            r_b_next <= calc_res.next;
            r_b_lim  <= calc_res.limited;
            r_w_cell <= r_b_cell;
            r_w_prev <= wr_prev;
            r_w_next <= wr_next;
        end
    end

    // the store read that fed the writeback stage misses the write made at that same edge
    always_comb begin
        fwd      = r_w_valid && (r_w_cell == r_b_cell);
        cur_prev = fwd ? r_w_prev : rd_data[COEF_W-1:0];
        cur_next = fwd ? r_w_next : rd_data[2*COEF_W-1:COEF_W];
        is_step  = r_step_frac >= FRAC_NEAR_ONE;

        if (r_pass_mode) begin
            wr_prev = cur_next;
            wr_next = '0;
        end else begin
            wr_prev = cur_prev;
            wr_next = is_step ? r_b_next : cur_next;
        end

        // prev + floor(t * (next - prev) / 2^16)
        blend_diff = $signed({1'b0, cur_next}) - $signed({1'b0, cur_prev});
        blend_prod = blend_diff * $signed({1'b0, r_step_frac});
        blend_sum  = $signed({{(FRAC_W+2){1'b0}}, cur_prev}) + (blend_prod >>> 16);
        src        = is_step ? cur_prev : blend_sum[COEF_W-1:0];

        push      = en && r_b_valid && !r_pass_mode;
        push_data = {(is_step ? r_b_next : cur_next), src, r_b_cell};
        push_user = is_step && r_b_lim;

        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = en && r_b_valid;
            ram_waddr = r_b_cell[AW-1:0];
            ram_wdata = {wr_next, wr_prev};
        end
    end

    assign pop = r_o_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (pop) begin
                r_s_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_o_valid && !pop) begin
                r_s_valid <= 1'b1;
            end else begin
                r_o_valid <= 1'b1;
            end
        end else if (pop) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (pop) begin
                r_o_data <= r_s_data;
                r_o_user <= r_s_user;
            end
        end else if (push) begin
            if (r_o_valid && !pop) begin
                r_s_data <= push_data;
                r_s_user <= push_user;
            end else begin
                r_o_data <= push_data;
                r_o_user <= push_user;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_o_data);
    assign o_m_tuser  = r_o_user;

    `IDC_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n,
        r_s_valid |-> r_o_valid, "skid full while output empty")
    `IDC_ASSERT_IMPL(a_no_accept_clear, i_clk, i_rst_n,
        r_clr_busy |-> !o_s_tready, "item taken during clear")
    `IDC_ASSERT_IMPL(a_cfg_when_empty, i_clk, i_rst_n,
        o_cfg_ready |-> (!r_b_valid && !calc_res.valid), "register write open with item in flight")
    `IDC_ASSERT_NEXT(a_skid_held, i_clk, i_rst_n,
        r_s_valid && !i_m_tready, r_s_valid && r_o_valid, "stalled result dropped")
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for implicit_drag_coefficient_cells: random and directed
// cell requests, predicted per-cell coefficients, checked in order. Needs idc_pkg.
module tb_top;
    import idc_pkg::*;

    // Expected output of one request, in order of acceptance.
    typedef struct {
        logic [CELL_W-1:0] cidx;
        logic [COEF_W-1:0] src;
        logic [COEF_W-1:0] nxt;
        logic              lim;
    } t_coeff_exp;

    // Holds the cell stores and register copies; predicts each result.
    class coeff_scoreboard;
        logic [COEF_W-1:0]  prev_mem [NUM_CELLS];
        logic [COEF_W-1:0]  next_mem [NUM_CELLS];
        logic [COEF_W-1:0]  lim_reg;
        logic [FRAC_W-1:0]  void_reg;
        logic [SPEED_W-1:0] speed_reg;
        logic [FRAC_W-1:0]  frac_reg;
        logic               rotate;
        t_coeff_exp         pending [$];
        int                 errors;
        int                 checked;
        int                 clamps;

        function new();
            foreach (prev_mem[i]) begin
                prev_mem[i] = '0;
                next_mem[i] = '0;
            end
            lim_reg = '1; void_reg = FRAC_ONE; speed_reg = SPEED_W'(1);
            frac_reg = FRAC_ONE; rotate = 0;
            errors = 0; checked = 0; clamps = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            case (idx)
                CFG_COEFF_LIMIT: lim_reg   = val;
                CFG_MAX_VOID:    void_reg  = val[FRAC_W-1:0];
                CFG_SMALL_SPEED: speed_reg = val[SPEED_W-1:0];
                CFG_STEP_FRAC:   frac_reg  = val[FRAC_W-1:0];
                CFG_PASS_MODE:   rotate    = val[0];
                default: ;
            endcase
        endfunction

        // floor sqrt of a value below 2^70
        function logic [34:0] isqrt(logic [69:0] v);
            logic [34:0] r;
            logic [34:0] c;
            r = '0;
            for (int b = 34; b >= 0; b--) begin
                c = r | (35'd1 << b);
                if ({70'd0, c} * {70'd0, c} <= {70'd0, v}) r = c;
            end
            return r;
        endfunction

        function logic [32:0] mag(logic signed [32:0] v);
            return v < 0 ? -v : v;
        endfunction

        function void note_request(t_in_item it);
            logic [CELL_W-1:0] c;
            logic [32:0]       dx, dy, dz;
            logic [34:0]       ur, fm;
            logic [69:0]       sum;
            logic [127:0]      q;
            logic [COEF_W-1:0] nxt;
            logic              lim;
            t_coeff_exp        e;
            c = it.cell_index;
            if (rotate) begin
                prev_mem[c] = next_mem[c];
                next_mem[c] = '0;
                return;
            end
            lim = 0;
            if (frac_reg >= FRAC_NEAR_ONE) begin
                dx = mag(33'(it.fluid_vel_x) - 33'(it.solid_vel_x));
                dy = mag(33'(it.fluid_vel_y) - 33'(it.solid_vel_y));
                dz = mag(33'(it.fluid_vel_z) - 33'(it.solid_vel_z));
                sum = 70'(dx) * dx + 70'(dy) * dy + 70'(dz) * dz;
                ur = isqrt(sum);
                nxt = '0;
                if (ur > speed_reg && it.void_fraction < void_reg) begin
                    dx = mag(33'(it.force_x)); dy = mag(33'(it.force_y));
                    dz = mag(33'(it.force_z));
                    sum = 70'(dx) * dx + 70'(dy) * dy + 70'(dz) * dz;
                    fm = isqrt(sum);
                    if (it.cell_volume == 0) q = 128'd1 << 64;
                    else q = (128'(fm) << 32) / (128'(ur) * it.cell_volume);
                    if (q <= 128'(lim_reg)) nxt = q[COEF_W-1:0];
                    else begin
                        nxt = lim_reg; lim = 1; clamps++;
                    end
                end
                next_mem[c] = nxt;
                e.src = prev_mem[c];
            end else begin
                q = (128'(FRAC_ONE - frac_reg) * prev_mem[c]
                     + 128'(frac_reg) * next_mem[c]) >> 16;
                e.src = q[COEF_W-1:0];
                nxt = next_mem[c];
            end
            e.cidx = c; e.nxt = nxt; e.lim = lim;
            pending.push_back(e);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, logic flag);
            t_coeff_exp e;
            if (pending.size() == 0) begin
                $error("unexpected result, cell %0d", d[CELL_W-1:0]);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d[CELL_W-1:0] !== e.cidx) begin
                $error("out_cell exp %0d got %0d", e.cidx, d[CELL_W-1:0]); errors++;
            end
            if (d[CELL_W +: COEF_W] !== e.src) begin
                $error("source_coeff exp %0h got %0h", e.src, d[CELL_W +: COEF_W]);
                errors++;
            end
            if (d[CELL_W+COEF_W +: COEF_W] !== e.nxt) begin
                $error("next_coeff exp %0h got %0h", e.nxt, d[CELL_W+COEF_W +: COEF_W]);
                errors++;
            end
            if (flag !== e.lim) begin
                $error("was_limited exp %0b got %0b", e.lim, flag); errors++;
            end
        endfunction
    endclass

    logic                     i_clk, i_rst_n;
    logic                     i_s_tvalid, o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata;
    logic                     o_m_tvalid, i_m_tready;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [COEF_W-1:0]        i_cfg_data;

    implicit_drag_coefficient_cells dut (.*);

    coeff_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;  // idle odds in percent
    bit  hold_recv;                     // long receiver hold-off in progress
    int  n_requests;
    logic [CELL_W-1:0] hot_cells [8];   // small set so rotate/blend revisit cells

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 0;
        else i_m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Drops the request line first so a finished request is not offered again.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        i_s_tvalid <= 0;
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic send_request(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= IN_TDATA_W'(it);
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(it);
        n_requests++;
    endtask

    // Wait for all results plus pipeline depth, so no rotate is still in flight.
    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT_CALC + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(200);      // near zero
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.cell_index  = $urandom_range(3) == 0 ? CELL_W'($urandom())
                                                : hot_cells[$urandom_range(7)];
        it.fluid_vel_x = rand_vel(); it.fluid_vel_y = rand_vel();
        it.fluid_vel_z = rand_vel(); it.solid_vel_x = rand_vel();
        it.solid_vel_y = rand_vel(); it.solid_vel_z = rand_vel();
        it.force_x = rand_vel(); it.force_y = rand_vel(); it.force_z = rand_vel();
        it.void_fraction = $urandom_range(4) == 0 ? 17'd65536
                                                  : FRAC_W'($urandom_range(65536));
        case ($urandom_range(4))
            0: it.cell_volume = 32'd0;
            1: it.cell_volume = 32'hffff_ffff;
            2: it.cell_volume = $urandom_range(16, 1);
            default: it.cell_volume = $urandom();
        endcase
        return it;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_request(rand_item());
        drain();
    endtask

    // Step / rotate / blend cycle, mostly over the hot cells, with the given settings.
    task automatic cycle_settings(logic [47:0] lim, logic [16:0] vmax,
                                  logic [15:0] spd, logic [16:0] frac, int count);
        write_reg(CFG_COEFF_LIMIT, lim);
        write_reg(CFG_MAX_VOID, vmax);
        write_reg(CFG_SMALL_SPEED, spd);
        write_reg(CFG_STEP_FRAC, FRAC_ONE);
        write_reg(CFG_PASS_MODE, 0);
        random_phase(count);
        write_reg(CFG_PASS_MODE, 1);
        random_phase(count / 3);
        write_reg(CFG_PASS_MODE, 0);
        random_phase(count / 3);
        write_reg(CFG_STEP_FRAC, frac);
        random_phase(count / 3);
    endtask

    initial begin
        t_in_item it;
        sb = new();
        n_requests = 0;
        hold_recv = 0;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        send_idle_pct = 0; recv_idle_pct = 0;
        foreach (hot_cells[i]) hot_cells[i] = CELL_W'($urandom());
        hot_cells[0] = '0; hot_cells[1] = CELL_W'(NUM_CELLS - 1);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, zero volume, speed at threshold, void at limit.
        it = '0;
        it.cell_index = '0; it.cell_volume = 32'd1; it.force_x = 32'h7fff_ffff;
        it.fluid_vel_x = 32'h0000_0002;
        send_request(it);                               // tiny speed, huge force: clamp
        it.cell_index = CELL_W'(NUM_CELLS - 1); it.fluid_vel_x = 32'h8000_0000;
        it.solid_vel_x = 32'h7fff_ffff; it.fluid_vel_y = 32'h8000_0000;
        it.solid_vel_z = 32'h7fff_ffff; it.force_y = 32'h8000_0000;
        it.force_z = 32'h8000_0000; it.cell_volume = 32'hffff_ffff;
        send_request(it);
        it.cell_volume = 32'd0; send_request(it);       // zero volume
        it.void_fraction = 17'd65536; send_request(it); // void fraction not below limit
        it = '0; it.cell_index = CELL_W'(5); it.cell_volume = 32'd7; it.force_x = 32'd1000;
        it.fluid_vel_x = 32'd1; send_request(it);       // speed at threshold
        it.fluid_vel_x = 32'd2; send_request(it);
        drain();
        write_reg(CFG_STEP_FRAC, 17'd65530);            // near one counts as one
        send_request(it);
        write_reg(CFG_STEP_FRAC, 17'h1ffff);            // above one counts as one
        send_request(it);
        drain();
        write_reg(CFG_PASS_MODE, 1);
        send_request(it);
        drain();
        write_reg(CFG_PASS_MODE, 0);
        write_reg(CFG_STEP_FRAC, 0);      send_request(it);
        write_reg(CFG_STEP_FRAC, 17'd65529); send_request(it);
        drain();

        // Random phases with the three idling patterns.
        send_idle_pct = 35; recv_idle_pct = 77;
        cycle_settings('1, 17'd65536, 16'd1, 17'd32768, 40);
        send_idle_pct = 77; recv_idle_pct = 35;
        cycle_settings(48'h0000_0001_0000, 17'd40000, 16'hffff, 17'd1, 40);
        send_idle_pct = 0; recv_idle_pct = 0;
        cycle_settings(48'h0, 17'd0, 16'd0, 17'd65529, 30);
        cycle_settings(48'h1234_5678_9abc, 17'd65535, 16'd300, 17'd12345, 40);

        // Long receiver hold-off while requests keep coming.
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge i_clk);
                hold_recv = 0;
            end
            repeat (100) send_request(rand_item());
        join
        drain();

        $display("Ran %0d requests, checked %0d results (%0d clamped) over several",
                 n_requests, sb.checked, sb.clamps);
        $display("register settings with step, rotate and blend passes.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: clearing pass, ~400 requests at worst stalls, drains and hold-off.
    initial begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/idc_pkg.sv
hdl/idc_ram.sv
hdl/idc_calc.sv
hdl/implicit_drag_coefficient_cells.sv
bench/tb_top.sv
